### rtl/cdsr_pkg.sv
// shared types, codes and tables for the clock digit segment refresh block
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package cdsr_pkg;

    localparam int CHANNELS   = 32;
    localparam int WORD_BITS  = 16;
    localparam int CH_BITS    = $clog2(CHANNELS);
    localparam int SEGS       = 8;
    localparam int SEG_BITS   = $clog2(SEGS);
    localparam int VALUE_BITS = 7;

    localparam logic [VALUE_BITS-1:0] PAIR_MAX = 7'd99;
    localparam logic [VALUE_BITS-1:0] DIGIT_MAX = 7'd9;

    typedef enum logic [1:0] {
        CMD_DIGIT   = 2'd0,
        CMD_HOURS   = 2'd1,
        CMD_MINUTES = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        LATCH_NONE     = 2'd0,
        LATCH_LAST_BIT = 2'd1,
        LATCH_FROM_13  = 2'd2
    } latch_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EMIT
    } state_t;

    // channel of each segment, segment a first, decimal point last
    localparam logic [CH_BITS-1:0] DIGIT_MAP [0:3][0:SEGS-1] = '{
        '{5'd26, 5'd20, 5'd4,  5'd2,  5'd0,  5'd28, 5'd30, 5'd6},
        '{5'd22, 5'd24, 5'd10, 5'd14, 5'd8,  5'd16, 5'd18, 5'd12},
        '{5'd11, 5'd9,  5'd21, 5'd19, 5'd17, 5'd13, 5'd15, 5'd23},
        '{5'd3,  5'd1,  5'd29, 5'd27, 5'd25, 5'd5,  5'd7,  5'd31}
    };

    localparam logic [SEGS-1:0] SEG_CODE [0:9] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6
    };

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                wr_en;
        logic [SEG_BITS-1:0] wr_idx;
        logic                sel_second;
        logic                push;
        logic [CH_BITS-1:0]  push_ch;
        logic                push_last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // segment pattern of a digit, blank above nine
    function automatic logic [SEGS-1:0] seg_pattern(input logic [VALUE_BITS-1:0] val);
        logic [SEGS-1:0] pat;
        pat = '0;
        if (val <= DIGIT_MAX)
        begin
            pat = SEG_CODE[val[3:0]];
        end
        return pat;
    endfunction

    function automatic latch_mode_t latch_of(input logic [CH_BITS-1:0] ch);
        latch_mode_t mode;
        if (ch == CH_BITS'(CHANNELS - 1))
        begin
            mode = LATCH_FROM_13;
        end
        else if (ch[0])
        begin
            mode = LATCH_LAST_BIT;
        end
        else
        begin
            mode = LATCH_NONE;
        end
        return mode;
    endfunction

endpackage

`default_nettype wire

### rtl/cdsr_ctrl.sv
// sequencer for the refresh block: segment write steps and word emission
// depends on cdsr_pkg; drives cdsr_datapath through ctrl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module cdsr_ctrl
    import cdsr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_command,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t              state_reg, state_next;
    logic [SEG_BITS-1:0] seg_reg, seg_next;
    logic [CH_BITS-1:0]  ch_reg, ch_next;
    logic                pair_reg, pair_next;
    logic                second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seg_reg    <= '0;
            ch_reg     <= '0;
            pair_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seg_reg    <= seg_next;
            ch_reg     <= ch_next;
            pair_reg   <= pair_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        seg_next    = seg_reg;
        ch_next     = ch_reg;
        pair_next   = pair_reg;
        second_next = second_reg;
        in_ready    = 1'b0;

        cmd            = '0;
        cmd.wr_idx     = seg_reg;
        cmd.sel_second = second_reg;
        cmd.push_ch    = ch_reg;
        cmd.push_last  = (ch_reg == CH_BITS'(CHANNELS - 1)) && (!pair_reg || second_reg);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // unused command code is taken and dropped
                if (in_valid && (in_command == CMD_DIGIT || in_command == CMD_HOURS
                                 || in_command == CMD_MINUTES))
                begin
                    cmd.load    = 1'b1;
                    pair_next   = (in_command != CMD_DIGIT);
                    second_next = 1'b0;
                    seg_next    = '0;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_en = 1'b1;
                seg_next  = seg_reg + 1'b1;
                if (seg_reg == SEG_BITS'(SEGS - 1))
                begin
                    ch_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    ch_next  = ch_reg + 1'b1;
                    if (ch_reg == CH_BITS'(CHANNELS - 1))
                    begin
                        if (pair_reg && !second_reg)
                        begin
                            second_next = 1'b1;
                            seg_next    = '0;
                            state_next  = ST_WRITE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/cdsr_datapath.sv
// channel level buffer, digit decode, brightness register and output word register
// depends on cdsr_pkg; commanded by cdsr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module cdsr_datapath
    import cdsr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic [1:0]            in_command,
    input  wire logic [1:0]            in_position,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic                  cfg_wr,
    input  wire logic [WORD_BITS-1:0]  cfg_wdata,
    output logic [WORD_BITS-1:0]       brightness,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [WORD_BITS-1:0]       out_word,
    output logic [CH_BITS-1:0]         out_channel,
    output latch_mode_t                out_mode,
    output logic                       out_last
);

    logic [WORD_BITS-1:0] bright_reg;
    logic [WORD_BITS-1:0] levels_reg [CHANNELS];
    logic [1:0]           pos_reg, pos_next;
    logic [SEGS-1:0]      pat_a_reg, pat_a_next;
    logic [SEGS-1:0]      pat_b_reg, pat_b_next;
    logic                 valid_reg, valid_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [CH_BITS-1:0]   chan_reg;
    latch_mode_t          mode_reg;
    logic                 last_reg;

    logic [VALUE_BITS-1:0] sat_val;
    logic [14:0]           tens_prod;
    logic [3:0]            tens;
    logic [VALUE_BITS-1:0] units;
    logic [1:0]            wr_pos;
    logic [SEGS-1:0]       wr_pat;
    logic [CH_BITS-1:0]    wr_ch;
    logic                  wr_lit;

    // tens by reciprocal multiply, exact for values up to 99
    always_comb
    begin
        sat_val   = (in_value > PAIR_MAX) ? PAIR_MAX : in_value;
        tens_prod = 15'(sat_val) * 15'd205;
        tens      = tens_prod[14:11];
        units     = sat_val - VALUE_BITS'(tens) * VALUE_BITS'(10);

        pos_next   = pos_reg;
        pat_a_next = pat_a_reg;
        pat_b_next = pat_b_reg;
        if (cmd.load)
        begin
            if (in_command == CMD_DIGIT)
            begin
                pos_next   = in_position;
                pat_a_next = seg_pattern(in_value);
            end
            else
            begin
                pos_next   = (in_command == CMD_HOURS) ? 2'd0 : 2'd2;
                pat_a_next = seg_pattern(VALUE_BITS'(tens));
            end
            pat_b_next = seg_pattern(units);
        end

        wr_pos = cmd.sel_second ? pos_reg + 2'd1 : pos_reg;
        wr_pat = cmd.sel_second ? pat_b_reg : pat_a_reg;
        wr_ch  = DIGIT_MAP[wr_pos][cmd.wr_idx];
        wr_lit = wr_pat[SEG_BITS'(SEGS - 1) - cmd.wr_idx];

        status.out_free = !valid_reg || out_ready;
        valid_next      = valid_reg;
        if (cmd.push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= WORD_BITS'(2000);
            valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                levels_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr)
            begin
                bright_reg <= cfg_wdata;
            end
            if (cmd.wr_en)
            begin
                levels_reg[wr_ch] <= wr_lit ? bright_reg : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        pat_a_reg <= pat_a_next;
        pat_b_reg <= pat_b_next;
        if (cmd.push)
        begin
            word_reg <= levels_reg[cmd.push_ch];
            chan_reg <= cmd.push_ch;
            mode_reg <= latch_of(cmd.push_ch);
            last_reg <= cmd.push_last;
        end
    end

    assign brightness  = bright_reg;
    assign out_valid   = valid_reg;
    assign out_word    = word_reg;
    assign out_channel = chan_reg;
    assign out_mode    = mode_reg;
    assign out_last    = last_reg;

endmodule

`default_nettype wire

### rtl/clock_digit_segment_refresh.sv
// top level of the four-digit clock display refresh block
// depends on cdsr_pkg, cdsr_ctrl and cdsr_datapath
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata: command, digit_position, value
//  m_        out        m_tvalid / m_tready    m_tdata: word, channel; m_tuser; m_tlast
//  apb       in         psel / penable         brightness register at address 0
//
// a digit write is accepted, its 8 segments are written (one buffer write port)
// and all 32 channel words are emitted; a pair write does so for each of its two digits
// reset loads brightness 2000 and clears all 32 channel levels at once
// output stalls hold the word register and pause the channel counter; s_tready
// is high only between writes, while the last word may still wait in the register
`timescale 1ns / 1ps
`default_nettype none

module clock_digit_segment_refresh
    import cdsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command[1:0], digit_position[3:2], value[10:4]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // word[15:0], channel[20:16]
    output logic [1:0]       m_tuser,   // latch_mode[1:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ctrl_cmd_t            cmd;
    dp_status_t           status;
    logic                 cfg_wr;
    logic [WORD_BITS-1:0] brightness;
    logic [WORD_BITS-1:0] out_word;
    logic [CH_BITS-1:0]   out_channel;
    latch_mode_t          out_mode;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'b0, brightness} : 32'b0;

    cdsr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tdata[1:0]),
        .in_ready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    cdsr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_command  (s_tdata[1:0]),
        .in_position (s_tdata[3:2]),
        .in_value    (s_tdata[10:4]),
        .cfg_wr      (cfg_wr),
        .cfg_wdata   (pwdata[15:0]),
        .brightness  (brightness),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_word    (out_word),
        .out_channel (out_channel),
        .out_mode    (out_mode),
        .out_last    (m_tlast)
    );

    assign m_tdata = {3'b000, out_channel, out_word};
    assign m_tuser = out_mode;

endmodule

`default_nettype wire

### dv/clock_digit_segment_refresh_checker.sv
// scoreboard for the clock digit segment refresh block: tracks the brightness register
// and the 32 channel levels, predicts every refresh word and compares the output stream
// depends on cdsr_pkg for the command and latch mode codes
`timescale 1ns / 1ps

module clock_digit_segment_refresh_checker
    import cdsr_pkg::*;
#(
    parameter logic [2:0] BRIGHTNESS_ADDR = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // command[1:0], digit_position[3:2], value[10:4]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // word[15:0], channel[20:16]
    input  logic [1:0]  m_tuser,    // latch_mode[1:0]
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          failures,
    output int          outstanding,
    output int          words_checked
);

    localparam logic [15:0] RESET_BRIGHTNESS = 16'd2000;
    localparam int          PAIR_LIMIT       = 99;

    // driver channel of each segment, segment a first
    localparam logic [4:0] SEGMENT_CHANNEL [0:3][0:7] = '{
        '{5'd26, 5'd20, 5'd4,  5'd2,  5'd0,  5'd28, 5'd30, 5'd6},
        '{5'd22, 5'd24, 5'd10, 5'd14, 5'd8,  5'd16, 5'd18, 5'd12},
        '{5'd11, 5'd9,  5'd21, 5'd19, 5'd17, 5'd13, 5'd15, 5'd23},
        '{5'd3,  5'd1,  5'd29, 5'd27, 5'd25, 5'd5,  5'd7,  5'd31}
    };

    localparam logic [7:0] SEVEN_SEG [0:9] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6
    };

    typedef struct packed {
        logic [15:0] level;
        logic [4:0]  channel;
        latch_mode_t mode;
        logic        last;
    } refresh_word_t;

    logic [15:0]   brightness;
    logic [15:0]   channel_level [0:31];
    refresh_word_t refresh_queue [$];

    task automatic store_digit(input int pos, input int val);
        logic [7:0] pattern;
        pattern = (val <= 9) ? SEVEN_SEG[val] : 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            channel_level[SEGMENT_CHANNEL[pos][k]] = pattern[7 - k] ? brightness : 16'h0000;
        end
    endtask

    task automatic queue_refresh(input logic closes);
        refresh_word_t w;
        for (int ch = 0; ch < 32; ch++)
        begin
            w.level   = channel_level[ch];
            w.channel = 5'(ch);
            if (ch == 31)
            begin
                w.mode = LATCH_FROM_13;
            end
            else if (ch % 2 == 1)
            begin
                w.mode = LATCH_LAST_BIT;
            end
            else
            begin
                w.mode = LATCH_NONE;
            end
            w.last = closes && (ch == 31);
            refresh_queue.push_back(w);
        end
    endtask

    task automatic predict_write(input logic [15:0] data);
        int pos;
        int val;
        int base;
        pos = data[3:2];
        val = data[10:4];
        case (data[1:0])
            CMD_DIGIT:
            begin
                store_digit(pos, val);
                queue_refresh(1'b1);
            end
            CMD_HOURS, CMD_MINUTES:
            begin
                if (val > PAIR_LIMIT)
                begin
                    val = PAIR_LIMIT;
                end
                base = (data[1:0] == CMD_HOURS) ? 0 : 2;
                store_digit(base, val / 10);
                queue_refresh(1'b0);
                store_digit(base + 1, val % 10);
                queue_refresh(1'b1);
            end
            default:
            begin
                // unused code: nothing stored, nothing sent
            end
        endcase
    endtask

    task automatic check_word();
        refresh_word_t w;
        if (refresh_queue.size() == 0)
        begin
            $error("unexpected word: channel %0d level %h", m_tdata[20:16], m_tdata[15:0]);
            failures++;
        end
        else
        begin
            w = refresh_queue.pop_front();
            words_checked++;
            if (m_tdata[15:0] !== w.level)
            begin
                $error("word: expected %h, got %h", w.level, m_tdata[15:0]);
                failures++;
            end
            if (m_tdata[20:16] !== w.channel)
            begin
                $error("channel: expected %0d, got %0d", w.channel, m_tdata[20:16]);
                failures++;
            end
            if (m_tuser !== w.mode)
            begin
                $error("latch_mode: expected %0d, got %0d", w.mode, m_tuser);
                failures++;
            end
            if (m_tlast !== w.last)
            begin
                $error("last: expected %0d, got %0d", w.last, m_tlast);
                failures++;
            end
        end
    endtask

    initial
    begin
        failures      = 0;
        outstanding   = 0;
        words_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness = RESET_BRIGHTNESS;
            for (int ch = 0; ch < 32; ch++)
            begin
                channel_level[ch] = 16'h0000;
            end
            refresh_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == BRIGHTNESS_ADDR)
            begin
                brightness = pwdata[15:0];
            end
            if (s_tvalid && s_tready)
            begin
                predict_write(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                check_word();
            end
        end
        outstanding = refresh_queue.size();
    end

endmodule

### dv/clock_digit_segment_refresh_test.sv
// top of the clock digit segment refresh testbench: clock, reset, write stimulus,
// output back-pressure, brightness updates over the register port and the verdict
// depends on cdsr_pkg, the block and clock_digit_segment_refresh_checker
`timescale 1ns / 1ps

module clock_digit_segment_refresh_test;
    import cdsr_pkg::*;

    localparam logic [1:0] CMD_RESERVED    = 2'd3;
    localparam logic [2:0] BRIGHTNESS_ADDR = 3'd0;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         HOLD_AT         = 40;
    localparam int         PHASE_WRITES    = 32;
    localparam int         DRAIN_CYCLES    = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;       // command[1:0], digit_position[3:2], value[10:4]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;       // word[15:0], channel[20:16]
    logic [1:0]  m_tuser;       // latch_mode[1:0]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int failures;
    int outstanding;
    int words_checked;
    int writes_sent;
    int settings_used;
    logic calm;

    always #6 clk = ~clk;

    clock_digit_segment_refresh dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    clock_digit_segment_refresh_checker #(
        .BRIGHTNESS_ADDR (BRIGHTNESS_ADDR)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .failures      (failures),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    // offer one write; returns at the falling edge after it is taken
    task automatic offer(input logic [1:0] cmd, input logic [1:0] pos, input logic [6:0] val);
        if (!calm && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tdata  <= {5'b0, val, pos, cmd};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (cmd != CMD_RESERVED)
        begin
            writes_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    task automatic set_brightness(input logic [15:0] level);
        drain();
        // an unused command leaves nothing to wait for, so give the block time to settle
        repeat (DRAIN_CYCLES) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= BRIGHTNESS_ADDR;
        pwdata  <= {16'h0000, level};
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // mostly legal writes, some out-of-range values and a few unused commands
    task automatic offer_random();
        logic [1:0] cmd;
        logic [6:0] val;
        if ($urandom_range(99) < 8)
        begin
            cmd = CMD_RESERVED;
            val = 7'($urandom_range(127));
        end
        else
        begin
            cmd = 2'($urandom_range(2));
            if (cmd == CMD_DIGIT)
            begin
                val = ($urandom_range(99) < 80) ? 7'($urandom_range(9))
                                                : 7'($urandom_range(10, 127));
            end
            else
            begin
                val = ($urandom_range(99) < 85) ? 7'($urandom_range(99))
                                                : 7'($urandom_range(100, 127));
            end
        end
        offer(cmd, 2'($urandom_range(3)), val);
    endtask

    task automatic random_phase(input bit pause_midway);
        int start;
        start = writes_sent;
        while (writes_sent - start < PHASE_WRITES)
        begin
            offer_random();
            if (pause_midway && writes_sent - start == PHASE_WRITES / 2)
            begin
                drain();
                pause_midway = 0;
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off while writes keep coming
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && writes_sent >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(99) < 26)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 16'h0000;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'h0;
        calm          = 1'b0;
        writes_sent   = 0;
        settings_used = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset brightness: blanking, saturation and the unused command
        offer(CMD_DIGIT, 2'd0, 7'd0);
        offer(CMD_DIGIT, 2'd1, 7'd9);
        offer(CMD_DIGIT, 2'd2, 7'd10);
        offer(CMD_DIGIT, 2'd3, 7'd127);
        offer(CMD_HOURS, 2'd1, 7'd0);
        offer(CMD_HOURS, 2'd3, 7'd99);
        offer(CMD_MINUTES, 2'd0, 7'd100);
        offer(CMD_MINUTES, 2'd1, 7'd127);
        offer(CMD_RESERVED, 2'd2, 7'd5);
        offer(CMD_RESERVED, 2'd3, 7'd127);
        offer(CMD_DIGIT, 2'd3, 7'd8);

        set_brightness(16'hffff);
        offer(CMD_HOURS, 2'd0, 7'd23);
        offer(CMD_MINUTES, 2'd0, 7'd59);
        offer(CMD_DIGIT, 2'd0, 7'd1);
        offer(CMD_DIGIT, 2'd1, 7'd7);

        set_brightness(16'h0000);
        offer(CMD_DIGIT, 2'd2, 7'd6);
        offer(CMD_HOURS, 2'd0, 7'd12);

        set_brightness(16'h0001);
        offer(CMD_MINUTES, 2'd0, 7'd34);
        offer(CMD_DIGIT, 2'd3, 7'd4);
        offer(CMD_DIGIT, 2'd0, 7'd2);
        offer(CMD_DIGIT, 2'd1, 7'd3);
        offer(CMD_DIGIT, 2'd2, 7'd5);

        set_brightness(16'($urandom_range(65535)));
        random_phase(0);

        // no idling on either side through this phase
        set_brightness(16'hffff);
        calm = 1'b1;
        random_phase(0);
        calm = 1'b0;

        set_brightness(16'h0000);
        random_phase(1);

        set_brightness(16'($urandom_range(1, 65534)));
        random_phase(0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d digit and pair writes (blanked, saturated, unused codes)",
                 writes_sent);
        $display("at %0d brightness settings; %0d channel words compared", settings_used,
                 words_checked);
        $display("with random stalls and a %0d-cycle output hold-off", HOLD_CYCLES);
        if (failures == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
